[rtl/mdt_pkg.sv]
// Package for the city-block distance transform block.
// Holds grid sizes, memory address widths, codes and the payload structs.
// No dependencies.
`default_nettype none

package mdt_pkg;

  // Grid capacity and derived widths
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DIST_W   = 7;
  localparam int DIM_W    = 7;

  localparam logic [DIST_W-1:0] UNREACHED = 7'd127;
  localparam logic [DIST_W-1:0] DIST_CAP  = 7'd126;
  localparam logic [DIM_W-1:0]  DIM_RESET = 7'd64;

  // Action codes
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_COMPUTE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam int PADDR_W = 3;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] row_index;
    logic [5:0] col_index;
    logic       cell_is_one;
  } in_item_t;

  typedef struct packed {
    logic              compute_done;
    logic [DIST_W-1:0] distance;
  } out_item_t;

  // Everything one cell update needs: own value and two neighbors
  typedef struct packed {
    logic              is_one;
    logic [DIST_W-1:0] own;
    logic              a_ok;
    logic [DIST_W-1:0] a_val;
    logic              b_ok;
    logic [DIST_W-1:0] b_val;
  } cell_nb_t;

endpackage

`default_nettype wire

[rtl/mdt_cell_update.sv]
// Distance update of one cell from its own value and two neighbors.
// Depends on mdt_pkg for widths, constants and the neighbor struct.
`default_nettype none

module mdt_cell_update (
  input  mdt_pkg::cell_nb_t              nb,
  output logic [mdt_pkg::DIST_W-1:0]     upd_dist
);
  import mdt_pkg::*;

  logic [DIST_W-1:0] cand_a;
  logic [DIST_W-1:0] cand_b;
  logic [DIST_W-1:0] best;

  // Neighbor plus one, saturated at the cap; unreached neighbors give nothing
  always_comb begin
    cand_a = UNREACHED;
    if (nb.a_ok && (nb.a_val != UNREACHED)) begin
      cand_a = (nb.a_val >= DIST_CAP) ? DIST_CAP : nb.a_val + DIST_W'(1);
    end
    cand_b = UNREACHED;
    if (nb.b_ok && (nb.b_val != UNREACHED)) begin
      cand_b = (nb.b_val >= DIST_CAP) ? DIST_CAP : nb.b_val + DIST_W'(1);
    end
  end

  // Take the minimum; source cells are zero
  always_comb begin
    best = nb.own;
    if (cand_a < best) begin
      best = cand_a;
    end
    if (cand_b < best) begin
      best = cand_b;
    end
    upd_dist = nb.is_one ? best : '0;
  end

endmodule

`default_nettype wire

[rtl/manhattan_distance_transform.sv]
// Top level of the city-block distance transform: handshakes, register port,
// cell and distance memories and the raster sequencer. Uses mdt_pkg, mdt_cell_update.
//
// A load transaction writes one cell of the cell map in the cycle it is accepted,
// if the cell lies in the grid in use, and the next transaction can be accepted
// in the cycle after. A read transaction does a registered read of the distance
// memory and then places the result in the output register. A compute transaction
// walks the R x C grid in use forward and then backward, with a memory read state
// and then an update and write-back state for each cell in each pass; the done
// result is placed in the output register after the backward pass, and the input
// side is stalled until then. The distance memory has two read ports so the
// backward pass can fetch a cell's forward value and its lower neighbor together.
// Left and right neighbors come from the value written one cell earlier. Both
// memories are uninitialized: compute only cells that were loaded, read only after
// a compute. Registers: rows at byte 0, columns at byte 4, both reset to 64.
`default_nettype none

module manhattan_distance_transform (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mdt_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mdt_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mdt_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mdt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FWD_RD = 7'b0000010,
    S_FWD_WR = 7'b0000100,
    S_BWD_RD = 7'b0001000,
    S_BWD_WR = 7'b0010000,
    S_READ   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DIM_W-1:0]  rows_r, cols_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [DIST_W-1:0] prev_r;
  logic              outside_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [DIM_W-1:0]  eff_rows, eff_cols, rows_m1, cols_m1;
  logic              in_fire, out_fire, cfg_wr, in_grid;
  logic              row_first, row_last, col_first, col_last;

  logic              cell_mem [MAX_ROWS*MAX_COLS];
  logic [DIST_W-1:0] dist_mem [MAX_ROWS*MAX_COLS];
  logic [ADDR_W-1:0] cell_addr, a_addr, b_addr, in_addr;
  logic              cell_r;
  logic [DIST_W-1:0] ram_a_r, ram_b_r;
  logic              dist_we, cell_we;

  cell_nb_t          nb;
  logic [DIST_W-1:0] new_dist;

  // Handshakes and effective grid size
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign eff_rows = (rows_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_r;
  assign eff_cols = (cols_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_r;
  assign rows_m1  = eff_rows - DIM_W'(1);
  assign cols_m1  = eff_cols - DIM_W'(1);
  assign in_grid  = (DIM_W'(in_data.row_index) < eff_rows) &&
                    (DIM_W'(in_data.col_index) < eff_cols);

  assign row_first = (row_r == '0);
  assign col_first = (col_r == '0);
  assign row_last  = (DIM_W'(row_r) == rows_m1);
  assign col_last  = (DIM_W'(col_r) == cols_m1);

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_r) : 32'(rows_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_RESET;
      cols_r <= DIM_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROWS) begin
        rows_r <= pwdata[DIM_W-1:0];
      end else begin
        cols_r <= pwdata[DIM_W-1:0];
      end
    end
  end

  // Memory addresses: port A is the read target, the upper neighbor or the own cell
  assign in_addr   = {in_data.row_index[ROW_W-1:0], in_data.col_index[COL_W-1:0]};
  assign cell_addr = {row_r, col_r};
  assign b_addr    = {row_r + ROW_W'(1), col_r};
  always_comb begin
    case (state_r)
      S_IDLE:   a_addr = in_addr;
      S_FWD_RD: a_addr = {row_r - ROW_W'(1), col_r};
      default:  a_addr = {row_r, col_r};
    endcase
  end

  assign cell_we = in_fire && (in_data.action == ACT_LOAD) && in_grid;
  assign dist_we = (state_r == S_FWD_WR) || (state_r == S_BWD_WR);

  // Cell map: write on load, registered read
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[in_addr] <= in_data.cell_is_one;
    end
    cell_r <= cell_mem[cell_addr];
  end

  // Distance memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[cell_addr] <= new_dist;
    end
    ram_a_r <= dist_mem[a_addr];
    ram_b_r <= dist_mem[b_addr];
  end

  // Neighbor selection per pass
  always_comb begin
    nb.is_one = cell_r;
    if (state_r == S_FWD_WR) begin
      nb.own   = UNREACHED;
      nb.a_ok  = !row_first;
      nb.a_val = ram_a_r;
      nb.b_ok  = !col_first;
      nb.b_val = prev_r;
    end else begin
      nb.own   = ram_a_r;
      nb.a_ok  = !row_last;
      nb.a_val = ram_b_r;
      nb.b_ok  = !col_last;
      nb.b_val = prev_r;
    end
  end

  mdt_cell_update u_update (
    .nb       (nb),
    .upd_dist (new_dist)
  );

  // Sequencer: advance the raster walk, drive results
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r && !out_fire;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.action)
            ACT_COMPUTE: begin
              row_nxt = '0;
              col_nxt = '0;
              if ((eff_rows == '0) || (eff_cols == '0)) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_FWD_RD;
              end
            end
            ACT_READ: state_nxt = S_READ;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_FWD_RD: state_nxt = S_FWD_WR;
      S_FWD_WR: begin
        state_nxt = S_FWD_RD;
        if (col_last) begin
          col_nxt = '0;
          if (row_last) begin
            row_nxt   = rows_m1[ROW_W-1:0];
            col_nxt   = cols_m1[COL_W-1:0];
            state_nxt = S_BWD_RD;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      S_BWD_RD: state_nxt = S_BWD_WR;
      S_BWD_WR: begin
        state_nxt = S_BWD_RD;
        if (col_first) begin
          col_nxt = cols_m1[COL_W-1:0];
          if (row_first) begin
            state_nxt = S_DONE;
          end else begin
            row_nxt = row_r - ROW_W'(1);
          end
        end else begin
          col_nxt = col_r - COL_W'(1);
        end
      end
      S_READ: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.compute_done = 1'b0;
        out_data_nxt.distance     = outside_r ? UNREACHED : ram_a_r;
        state_nxt                 = S_IDLE;
      end
      S_DONE: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.compute_done = 1'b1;
        out_data_nxt.distance     = '0;
        state_nxt                 = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    out_data_r <= out_data_nxt;
    if (dist_we) begin
      prev_r <= new_dist;
    end
    if (in_fire) begin
      outside_r <= !in_grid;
    end
  end

`ifndef ASSERT_OFF
  // Walk stays inside the grid in use
  a_walk_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWD_RD || state_r == S_FWD_WR ||
     state_r == S_BWD_RD || state_r == S_BWD_WR) |->
    (DIM_W'(row_r) < eff_rows) && (DIM_W'(col_r) < eff_cols))
    else $error("raster walk left the grid");

  // Each memory read is followed by its write-back
  a_fwd_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWD_RD) |=> (state_r == S_FWD_WR))
    else $error("forward read not followed by write-back");

  a_bwd_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BWD_RD) |=> (state_r == S_BWD_WR))
    else $error("backward read not followed by write-back");

  // A result appears only after a read or a finished compute
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_READ || state_r == S_DONE))
    else $error("result without a read or compute");

  // A done result carries zero distance
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.compute_done) |-> (out_data_r.distance == '0))
    else $error("done result with nonzero distance");
`endif

endmodule

`default_nettype wire
